// ----- design/quadratic_ode3_euler_step_assert.svh -----
// ----------------------------------------------------------------------------
// quadratic_ode3_euler_step assertion macros
// Concurrent assertion helpers, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ODE3_EULER_STEP_ASSERT_SVH
`define QUADRATIC_ODE3_EULER_STEP_ASSERT_SVH

// same-cycle implication
`define QODE3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QODE3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/qode3_pkg.sv -----
// ----------------------------------------------------------------------------
// qode3_pkg
// Types, constants and op decode for the three-axis quadratic Euler stepper.
// ----------------------------------------------------------------------------
package qode3_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int ACC_W      = DATA_W + 4;
  localparam int NCOEF      = 30;
  localparam int COEF_AW    = 5;
  localparam int REG_AW     = 3;
  localparam int OP_W       = 6;
  localparam int TERMS_AXIS = 10;

  // op sequence layout
  localparam int COEF_BASE   = 6;
  localparam int VEL_BASE    = COEF_BASE + 3 * TERMS_AXIS;
  localparam int SQ_BASE     = VEL_BASE + 3;
  localparam int UPD_BASE    = SQ_BASE + 3;
  localparam int OPS_RESTART = UPD_BASE;
  localparam int OPS_STEP    = UPD_BASE + 3;

  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] Q_ONE =
    {{(DATA_W-FRAC_W-1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};

  typedef enum logic [1:0] {
    MODE_COEF    = 2'd0,
    MODE_RESTART = 2'd1,
    MODE_STEP    = 2'd2
  } mode_e;

  typedef enum logic [REG_AW-1:0] {
    REG_TIME_STEP = 3'd0,
    REG_GAIN_X    = 3'd1,
    REG_GAIN_Y    = 3'd2,
    REG_GAIN_Z    = 3'd3,
    REG_START_X   = 3'd4,
    REG_START_Y   = 3'd5,
    REG_START_Z   = 3'd6
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_SQRT,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TERM,
    OP_COEF,
    OP_VEL,
    OP_SQ,
    OP_UPD
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [1:0] axis;
    logic [3:0] sel;
  } op_t;

  typedef struct packed {
    logic [1:0]               mode;
    logic [COEF_AW-1:0]       coef_index;
    logic signed [DATA_W-1:0] coef_value;
    logic signed [DATA_W-1:0] drive_x;
    logic signed [DATA_W-1:0] drive_y;
    logic signed [DATA_W-1:0] drive_z;
  } qode3_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic [DATA_W-2:0]        speed;
    logic                     overflow;
  } qode3_out_t;

  localparam op_t OP_IDLE = '{kind: OP_NONE, axis: 2'd0, sel: 4'd0};

  function automatic op_t op_decode(input logic [OP_W-1:0] idx);
    op_t             op;
    logic [OP_W-1:0] rel;
    op  = OP_IDLE;
    rel = '0;
    if (idx < OP_W'(COEF_BASE)) begin
      op.kind = OP_TERM;
      op.sel  = idx[3:0];
    end else if (idx < OP_W'(COEF_BASE + TERMS_AXIS)) begin
      rel     = idx - OP_W'(COEF_BASE);
      op.kind = OP_COEF;
      op.axis = 2'd0;
      op.sel  = rel[3:0];
    end else if (idx < OP_W'(COEF_BASE + 2 * TERMS_AXIS)) begin
      rel     = idx - OP_W'(COEF_BASE + TERMS_AXIS);
      op.kind = OP_COEF;
      op.axis = 2'd1;
      op.sel  = rel[3:0];
    end else if (idx < OP_W'(VEL_BASE)) begin
      rel     = idx - OP_W'(COEF_BASE + 2 * TERMS_AXIS);
      op.kind = OP_COEF;
      op.axis = 2'd2;
      op.sel  = rel[3:0];
    end else if (idx < OP_W'(SQ_BASE)) begin
      rel     = idx - OP_W'(VEL_BASE);
      op.kind = OP_VEL;
      op.axis = rel[1:0];
    end else if (idx < OP_W'(UPD_BASE)) begin
      rel     = idx - OP_W'(SQ_BASE);
      op.kind = OP_SQ;
      op.axis = rel[1:0];
    end else if (idx < OP_W'(OPS_STEP)) begin
      rel     = idx - OP_W'(UPD_BASE);
      op.kind = OP_UPD;
      op.axis = rel[1:0];
    end
    return op;
  endfunction

  // square / cross product operand axes: xx yy zz xy yz xz
  function automatic logic [1:0] term_lhs(input logic [3:0] sel);
    logic [1:0] a;
    case (sel[2:0])
      3'd1:    a = 2'd1;
      3'd2:    a = 2'd2;
      3'd4:    a = 2'd1;
      default: a = 2'd0;
    endcase
    return a;
  endfunction

  function automatic logic [1:0] term_rhs(input logic [3:0] sel);
    logic [1:0] b;
    case (sel[2:0])
      3'd1:    b = 2'd1;
      3'd2:    b = 2'd2;
      3'd3:    b = 2'd1;
      3'd4:    b = 2'd2;
      3'd5:    b = 2'd2;
      default: b = 2'd0;
    endcase
    return b;
  endfunction

endpackage

// ----- design/qode3_chan_if.sv -----
// ----------------------------------------------------------------------------
// qode3_chan_if
// Valid/ready stream channel; a beat moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface qode3_chan_if #(
  parameter type payload_t = logic [0:0]
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (
    output valid,
    output data,
    input  ready
  );

  modport sink (
    input  valid,
    input  data,
    output ready
  );

endinterface

// ----- design/quadratic_ode3_euler_step.sv -----
// ----------------------------------------------------------------------------
// quadratic_ode3_euler_step: 3-axis forward-Euler stepper, Q16.16, saturating
// Restart runs 42 products, step 45, on one shared 32x32 multiplier, then a
// bit-serial square root; no new beat is taken until the result is loaded.
// Coefficient beats leave it idle. Async active-low reset: state, table zero.
// ----------------------------------------------------------------------------
`include "quadratic_ode3_euler_step_assert.svh"

module quadratic_ode3_euler_step (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [qode3_pkg::REG_AW-1:0]      cfg_index_i,
  input  logic [qode3_pkg::DATA_W-1:0]      cfg_data_i,
  qode3_chan_if.sink                        in_chan,
  qode3_chan_if.source                      out_chan
);

  import qode3_pkg::*;

  state_e                    st_q, st_d;
  logic [OP_W-1:0]           cnt_q, cnt_d;
  op_t                       op_now, op1_q, op2_q;
  logic                      step_q;

  logic [DATA_W-2:0]         ts_q;
  logic signed [DATA_W-1:0]  gain_q  [0:2];
  logic signed [DATA_W-1:0]  start_q [0:2];
  logic signed [DATA_W-1:0]  state_q [0:2];

  logic signed [DATA_W-1:0]  coef_mem [0:NCOEF-1];
  logic [NCOEF-1:0]          coef_vld_q;
  logic signed [DATA_W-1:0]  coef_rd_q;
  logic                      coef_rd_vld_q;
  logic [COEF_AW-1:0]        rd_addr;

  logic signed [DATA_W-1:0]  term_q [0:5];
  logic signed [ACC_W-1:0]   acc_q  [0:2];
  logic signed [DATA_W-1:0]  v_q    [0:2];
  logic [PROD_W-1:0]         ss_q;
  logic signed [PROD_W-1:0]  p_q;
  logic                      ovf_q;

  logic [PROD_W-1:0]         sq_rem_q, sq_res_q, sq_bit_q, sq_sum;

  logic                      out_valid_q;
  qode3_out_t                out_q;

  logic                      in_acc, run_mode, run_start, sq_load, out_load;
  logic [OP_W-1:0]           n_ops, run_last;

  logic signed [DATA_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod, shifted;
  logic signed [DATA_W-1:0]  fm;
  logic                      fm_ovf;
  logic signed [ACC_W-1:0]   acc_sel;
  logic signed [DATA_W-1:0]  acc_sat;
  logic                      acc_ovf;
  logic signed [DATA_W:0]    upd_sum;
  logic signed [DATA_W-1:0]  upd_val;
  logic                      upd_ovf;
  logic                      post_ovf, vel_ovf, spd_ovf;
  logic [DATA_W-2:0]         speed;

  assign in_chan.ready  = (st_q == ST_IDLE);
  assign in_acc         = in_chan.valid && (st_q == ST_IDLE);
  assign run_mode       = (in_chan.data.mode == MODE_RESTART) ||
                          (in_chan.data.mode == MODE_STEP);
  assign out_chan.valid = out_valid_q;
  assign out_chan.data  = out_q;

  assign n_ops    = step_q ? OP_W'(OPS_STEP) : OP_W'(OPS_RESTART);
  assign run_last = step_q ? OP_W'(OPS_STEP + 2) : OP_W'(OPS_RESTART + 2);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    run_start = 1'b0;
    sq_load   = 1'b0;
    out_load  = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (in_acc && run_mode) begin
          st_d      = ST_RUN;
          cnt_d     = '0;
          run_start = 1'b1;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + OP_W'(1);
        if (cnt_q == run_last) begin
          st_d    = ST_SQRT;
          sq_load = 1'b1;
        end
      end
      ST_SQRT: begin
        if (sq_bit_q[0]) st_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_chan.ready) begin
          out_load = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // op pipeline: address/decode -> multiply -> post
  always_comb begin
    op_now = OP_IDLE;
    if (st_q == ST_RUN && cnt_q < n_ops) op_now = op_decode(cnt_q);
  end

  assign rd_addr = (op_now.kind == OP_COEF) ?
                   COEF_AW'(cnt_q - OP_W'(COEF_BASE)) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op1_q  <= OP_IDLE;
      op2_q  <= OP_IDLE;
      step_q <= 1'b0;
    end else begin
      op1_q <= op_now;
      op2_q <= op1_q;
      if (run_start) step_q <= (in_chan.data.mode == MODE_STEP);
    end
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q    <= (DATA_W-1)'(655);
      gain_q  <= '{default: Q_ONE};
      start_q <= '{default: '0};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TIME_STEP: ts_q       <= cfg_data_i[DATA_W-2:0];
        REG_GAIN_X:    gain_q[0]  <= cfg_data_i;
        REG_GAIN_Y:    gain_q[1]  <= cfg_data_i;
        REG_GAIN_Z:    gain_q[2]  <= cfg_data_i;
        REG_START_X:   start_q[0] <= cfg_data_i;
        REG_START_Y:   start_q[1] <= cfg_data_i;
        REG_START_Z:   start_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- coefficient table ----------------
  always_ff @(posedge clk_i) begin
    if (in_acc && in_chan.data.mode == MODE_COEF &&
        in_chan.data.coef_index < COEF_AW'(NCOEF)) begin
      coef_mem[in_chan.data.coef_index] <= in_chan.data.coef_value;
    end
    coef_rd_q <= coef_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q    <= '0;
      coef_rd_vld_q <= 1'b0;
    end else begin
      if (in_acc && in_chan.data.mode == MODE_COEF &&
          in_chan.data.coef_index < COEF_AW'(NCOEF)) begin
        coef_vld_q[in_chan.data.coef_index] <= 1'b1;
      end
      coef_rd_vld_q <= coef_vld_q[rd_addr];
    end
  end

  // ---------------- shared multiplier ----------------
  always_comb begin
    acc_sel = acc_q[op1_q.axis];
    acc_ovf = (acc_sel > ACC_W'(Q_MAX)) || (acc_sel < ACC_W'(Q_MIN));
    acc_sat = acc_ovf ? (acc_sel[ACC_W-1] ? Q_MIN : Q_MAX) : acc_sel[DATA_W-1:0];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op1_q.kind)
      OP_TERM: begin
        mul_a = state_q[term_lhs(op1_q.sel)];
        mul_b = state_q[term_rhs(op1_q.sel)];
      end
      OP_COEF: begin
        mul_a = coef_rd_vld_q ? coef_rd_q : '0;
        if (op1_q.sel == 4'd0) begin
          mul_b = Q_ONE;
        end else if (op1_q.sel < 4'd4) begin
          mul_b = state_q[op1_q.sel[1:0] - 2'd1];
        end else begin
          mul_b = term_q[3'(op1_q.sel - 4'd4)];
        end
      end
      OP_VEL: begin
        mul_a = gain_q[op1_q.axis];
        mul_b = acc_sat;
      end
      OP_SQ: begin
        mul_a = v_q[op1_q.axis];
        mul_b = v_q[op1_q.axis];
      end
      OP_UPD: begin
        mul_a = {1'b0, ts_q};
        mul_b = v_q[op1_q.axis];
      end
      default: ;
    endcase
  end

  assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign vel_ovf = (op1_q.kind == OP_VEL) && acc_ovf;

  // post stage: floor shift and saturate the registered product
  always_comb begin
    shifted = p_q >>> FRAC_W;
    fm_ovf  = (shifted > PROD_W'(Q_MAX)) || (shifted < PROD_W'(Q_MIN));
    fm      = fm_ovf ? (shifted[PROD_W-1] ? Q_MIN : Q_MAX) : shifted[DATA_W-1:0];
    upd_sum = (DATA_W+1)'(state_q[op2_q.axis]) + (DATA_W+1)'(fm);
    upd_ovf = upd_sum[DATA_W] != upd_sum[DATA_W-1];
    upd_val = upd_ovf ? (upd_sum[DATA_W] ? Q_MIN : Q_MAX) : upd_sum[DATA_W-1:0];
    case (op2_q.kind)
      OP_TERM, OP_COEF, OP_VEL: post_ovf = fm_ovf;
      OP_UPD:                   post_ovf = fm_ovf || upd_ovf;
      default:                  post_ovf = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= prod;
    if (run_start) begin
      acc_q[0] <= ACC_W'(in_chan.data.drive_x);
      acc_q[1] <= ACC_W'(in_chan.data.drive_y);
      acc_q[2] <= ACC_W'(in_chan.data.drive_z);
      ss_q     <= '0;
    end
    case (op2_q.kind)
      OP_TERM: term_q[op2_q.sel[2:0]] <= fm;
      OP_COEF: acc_q[op2_q.axis]      <= acc_q[op2_q.axis] + ACC_W'(fm);
      OP_VEL:  v_q[op2_q.axis]        <= fm;
      OP_SQ:   ss_q                   <= ss_q + $unsigned(p_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{default: '0};
      ovf_q   <= 1'b0;
    end else begin
      if (run_start && in_chan.data.mode == MODE_RESTART) state_q <= start_q;
      if (op2_q.kind == OP_UPD) state_q[op2_q.axis] <= upd_val;
      if (run_start) begin
        ovf_q <= 1'b0;
      end else if (post_ovf || vel_ovf) begin
        ovf_q <= 1'b1;
      end
    end
  end

  // ---------------- square root, one result bit per cycle ----------------
  assign sq_sum = sq_res_q + sq_bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_bit_q <= '0;
    end else if (sq_load) begin
      sq_bit_q <= PROD_W'(1) << (PROD_W - 2);
    end else if (st_q == ST_SQRT) begin
      sq_bit_q <= sq_bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_load) begin
      sq_rem_q <= ss_q;
      sq_res_q <= '0;
    end else if (st_q == ST_SQRT) begin
      if (sq_rem_q >= sq_sum) begin
        sq_rem_q <= sq_rem_q - sq_sum;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
    end
  end

  assign spd_ovf = |sq_res_q[PROD_W-1:DATA_W-1];
  assign speed   = spd_ovf ? {(DATA_W-1){1'b1}} : sq_res_q[DATA_W-2:0];

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.pos_x    <= state_q[0];
      out_q.pos_y    <= state_q[1];
      out_q.pos_z    <= state_q[2];
      out_q.speed    <= speed;
      out_q.overflow <= ovf_q || spd_ovf;
    end
  end

  // ---------------- assertions ----------------
  `QODE3_ASSERT_NEXT(a_run_start, clk_i, rst_ni, in_acc && run_mode,
                     st_q == ST_RUN && cnt_q == '0, "run beat did not start sequencer")
  `QODE3_ASSERT_NEXT(a_coef_no_run, clk_i, rst_ni,
                     in_acc && in_chan.data.mode == MODE_COEF,
                     st_q == ST_IDLE, "coefficient beat left idle")
  `QODE3_ASSERT_NOW(a_sqrt_bit, clk_i, rst_ni, st_q == ST_SQRT,
                    $onehot(sq_bit_q), "square root bit not one-hot")
  `QODE3_ASSERT_NEXT(a_ovf_sticky, clk_i, rst_ni, st_q == ST_RUN && ovf_q,
                     ovf_q, "overflow flag dropped during run")
  `QODE3_ASSERT_NEXT(a_out_load, clk_i, rst_ni,
                     st_q == ST_FIN && (!out_valid_q || out_chan.ready),
                     out_valid_q && st_q == ST_IDLE, "result not loaded")

endmodule

// ----- tb/sv/quadratic_ode3_euler_step_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadratic_ode3_euler_step_checker
// Follows the register writes and the input beats, integrates its own copy
// of the three-axis state and coefficient table, and compares every result
// beat field by field with the oldest predicted point.
// ----------------------------------------------------------------------------
module quadratic_ode3_euler_step_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [qode3_pkg::REG_AW-1:0] cfg_index_i,
  input  logic [qode3_pkg::DATA_W-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  qode3_pkg::qode3_in_t         in_beat_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  qode3_pkg::qode3_out_t        out_beat_i,
  output int                           errors_o,
  output int                           pending_o
);

  import qode3_pkg::*;

  localparam longint QHI      = 64'sh0000_0000_7fff_ffff;
  localparam longint QLO      = -QHI - 1;

  longint     step_len;
  longint     gain [3];
  longint     start [3];
  longint     pos [3];
  longint     rate [3];
  longint     coef [NCOEF];
  bit         sat_hit;
  qode3_out_t trajectory_q [$];
  int         faults = 0;
  int         points_due = 0;

  assign errors_o  = faults;
  assign pending_o = points_due;

  function automatic longint clamp(input longint a);
    if (a > QHI) begin
      sat_hit = 1'b1;
      return QHI;
    end
    if (a < QLO) begin
      sat_hit = 1'b1;
      return QLO;
    end
    return a;
  endfunction

  // exact product, floor shift, saturate
  function automatic longint qmul(input longint a, input longint b);
    return clamp((a * b) >>> FRAC_W);
  endfunction

  function automatic longint unsigned isqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n    = n - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // rate vector at the current state into rate[], returns its magnitude
  function automatic longint rate_speed(input longint dx, input longint dy, input longint dz);
    longint          term [10];
    longint          drv [3];
    longint          acc;
    longint          sp;
    longint unsigned mag;
    longint unsigned ss;
    int              a;
    int              k;
    drv[0]  = dx;
    drv[1]  = dy;
    drv[2]  = dz;
    term[0] = 0;
    term[1] = pos[0];
    term[2] = pos[1];
    term[3] = pos[2];
    term[4] = qmul(pos[0], pos[0]);
    term[5] = qmul(pos[1], pos[1]);
    term[6] = qmul(pos[2], pos[2]);
    term[7] = qmul(pos[0], pos[1]);
    term[8] = qmul(pos[1], pos[2]);
    term[9] = qmul(pos[0], pos[2]);
    ss = 0;
    for (a = 0; a < 3; a++) begin
      acc = drv[a] + coef[a * TERMS_AXIS];
      for (k = 1; k < TERMS_AXIS; k++) acc += qmul(coef[a * TERMS_AXIS + k], term[k]);
      rate[a] = qmul(gain[a], clamp(acc));
      mag = (rate[a] < 0) ? -rate[a] : rate[a];
      ss += mag * mag;
    end
    sp = longint'(isqrt(ss));
    if (sp > QHI) begin
      sat_hit = 1'b1;
      sp      = QHI;
    end
    return sp;
  endfunction

  task automatic reset_model();
    int k;
    step_len = 655;
    for (k = 0; k < 3; k++) begin
      gain[k]  = longint'(Q_ONE);
      start[k] = 0;
      pos[k]   = 0;
      rate[k]  = 0;
    end
    for (k = 0; k < NCOEF; k++) coef[k] = 0;
    trajectory_q.delete();
  endtask

  task automatic report(input string what, input longint got, input longint want);
    faults++;
    $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic apply_reg(input logic [REG_AW-1:0] idx, input logic [DATA_W-1:0] val);
    case (idx)
      REG_TIME_STEP: step_len = longint'(val[DATA_W-2:0]);
      REG_GAIN_X:    gain[0]  = longint'($signed(val));
      REG_GAIN_Y:    gain[1]  = longint'($signed(val));
      REG_GAIN_Z:    gain[2]  = longint'($signed(val));
      REG_START_X:   start[0] = longint'($signed(val));
      REG_START_Y:   start[1] = longint'($signed(val));
      REG_START_Z:   start[2] = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic integrate_beat(input qode3_in_t b);
    qode3_out_t pt;
    longint     sp;
    int         k;
    sat_hit = 1'b0;
    case (b.mode)
      MODE_COEF: begin
        if (b.coef_index < NCOEF) coef[b.coef_index] = longint'(b.coef_value);
      end
      MODE_RESTART, MODE_STEP: begin
        if (b.mode == MODE_RESTART) begin
          for (k = 0; k < 3; k++) pos[k] = clamp(start[k]);
          sp = rate_speed(longint'(b.drive_x), longint'(b.drive_y), longint'(b.drive_z));
        end else begin
          sp = rate_speed(longint'(b.drive_x), longint'(b.drive_y), longint'(b.drive_z));
          for (k = 0; k < 3; k++) pos[k] = clamp(pos[k] + qmul(step_len, rate[k]));
        end
        pt.pos_x    = pos[0][DATA_W-1:0];
        pt.pos_y    = pos[1][DATA_W-1:0];
        pt.pos_z    = pos[2][DATA_W-1:0];
        pt.speed    = sp[DATA_W-2:0];
        pt.overflow = sat_hit;
        trajectory_q.push_back(pt);
      end
      default: ;
    endcase
  endtask

  task automatic check_point(input qode3_out_t got);
    qode3_out_t want;
    if (trajectory_q.size() == 0) begin
      report("result beat with nothing pending, pos_x", longint'(got.pos_x), 0);
    end else begin
      want = trajectory_q.pop_front();
      if (got.pos_x !== want.pos_x) report("pos_x", longint'(got.pos_x), longint'(want.pos_x));
      if (got.pos_y !== want.pos_y) report("pos_y", longint'(got.pos_y), longint'(want.pos_y));
      if (got.pos_z !== want.pos_z) report("pos_z", longint'(got.pos_z), longint'(want.pos_z));
      if (got.speed !== want.speed) report("speed", longint'(got.speed), longint'(want.speed));
      if (got.overflow !== want.overflow)
        report("overflow", longint'(got.overflow), longint'(want.overflow));
    end
  endtask

  // result side first, so a beat leaving in the cycle a new one enters
  // is matched against what was already pending
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_model();
      points_due = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_point(out_beat_i);
      if (cfg_we_i) apply_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) integrate_beat(in_beat_i);
      points_due = trajectory_q.size();
    end
  end

endmodule

// ----- tb/sv/quadratic_ode3_euler_step_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadratic_ode3_euler_step_tb
// Drives coefficient, restart and step beats with random gaps on both
// streams across several register settings, extremes included; the checker
// beside the stepper predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module quadratic_ode3_euler_step_tb;

  import qode3_pkg::*;

  localparam int         HALF_NS      = 4;
  localparam int         RESET_CYCLES = 9;
  localparam int         MAX_GAP      = 18;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         DRAIN_CYCLES = 120;
  localparam int         PHASES       = 8;
  localparam int         PHASE_ITEMS  = 125;
  localparam int         LIMIT_NS     = 5_000_000;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [REG_AW-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  int                errors;
  int                points_due;
  bit                calm = 1'b0;
  bit                hold_req = 1'b0;
  int                n_coef = 0;
  int                n_restart = 0;
  int                n_step = 0;
  int                n_ignored = 0;
  int                n_regs = 0;
  int                p;

  qode3_chan_if #(.payload_t(qode3_in_t))  in_chan ();
  qode3_chan_if #(.payload_t(qode3_out_t)) out_chan ();

  quadratic_ode3_euler_step DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_chan     (in_chan),
    .out_chan    (out_chan)
  );

  quadratic_ode3_euler_step_checker u_monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_chan.valid),
    .in_ready_i  (in_chan.ready),
    .in_beat_i   (in_chan.data),
    .out_valid_i (out_chan.valid),
    .out_ready_i (out_chan.ready),
    .out_beat_i  (out_chan.data),
    .errors_o    (errors),
    .pending_o   (points_due)
  );

  always #(HALF_NS) clk_i = ~clk_i;

  initial begin
    #(LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stall per beat, one long hold on request
  initial begin
    int gap;
    out_chan.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        gap      = HOLD_CYCLES;
      end else begin
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk_i); while (!out_chan.valid);
    end
  end

  function automatic logic [DATA_W-1:0] rand_q();
    case ($urandom_range(0, 11))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return Q_ONE;
      4, 5:    return $urandom;
      default: return DATA_W'($urandom_range(0, 32'h3ffff)) - 32'h20000;
    endcase
  endfunction

  function automatic qode3_in_t coef_beat(input logic [COEF_AW-1:0] idx,
                                          input logic [DATA_W-1:0] val);
    qode3_in_t b;
    b.mode       = MODE_COEF;
    b.coef_index = idx;
    b.coef_value = val;
    b.drive_x    = $urandom;
    b.drive_y    = $urandom;
    b.drive_z    = $urandom;
    return b;
  endfunction

  function automatic qode3_in_t run_beat(input logic [1:0] mode, input logic [DATA_W-1:0] dx,
                                         input logic [DATA_W-1:0] dy,
                                         input logic [DATA_W-1:0] dz);
    qode3_in_t b;
    b.mode       = mode;
    b.coef_index = COEF_AW'($urandom);
    b.coef_value = $urandom;
    b.drive_x    = dx;
    b.drive_y    = dy;
    b.drive_z    = dz;
    return b;
  endfunction

  task automatic send_beat(input qode3_in_t b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk_i);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= b;
    do @(posedge clk_i); while (!in_chan.ready);
    case (b.mode)
      MODE_COEF: begin
        if (b.coef_index < NCOEF) n_coef++;
        else n_ignored++;
      end
      MODE_RESTART: n_restart++;
      MODE_STEP:    n_step++;
      default:      n_ignored++;
    endcase
  endtask

  // drop valid, wait for every pending point, then let the pipe go quiet
  task automatic settle();
    @(negedge clk_i);
    in_chan.valid <= 1'b0;
    wait (points_due == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    n_regs++;
  endtask

  task automatic load_setting(input int ph);
    logic [DATA_W-1:0] ts;
    case (ph)
      0:       ts = '0;
      1:       ts = 32'h7fff_ffff;
      2:       ts = 32'd655;
      default: ts = ($urandom_range(0, 3) == 0) ? $urandom
                                                : DATA_W'($urandom_range(0, 32'h4000));
    endcase
    ts[DATA_W-1] = 1'($urandom_range(0, 1));
    write_reg(REG_TIME_STEP, ts);
    write_reg(REG_GAIN_X, (ph == 1) ? Q_MAX : (ph == 3) ? Q_MIN : rand_q());
    write_reg(REG_GAIN_Y, (ph == 1) ? Q_MIN : (ph == 3) ? Q_MAX : rand_q());
    write_reg(REG_GAIN_Z, (ph == 1) ? '0 : (ph == 3) ? Q_ONE : rand_q());
    write_reg(REG_START_X, (ph == 1) ? Q_MAX : (ph == 3) ? Q_MIN : rand_q());
    write_reg(REG_START_Y, (ph == 1) ? Q_MIN : (ph == 3) ? Q_MAX : rand_q());
    write_reg(REG_START_Z, (ph == 1) ? Q_MAX : (ph == 3) ? Q_MIN : rand_q());
  endtask

  // mostly groups of coefficient loads, a restart and a run of steps; some raw noise
  task automatic run_phase(input int ph);
    int        goal;
    int        n;
    qode3_in_t b;
    goal = n_coef + n_restart + n_step + PHASE_ITEMS;
    if (ph == 2) hold_req = 1'b1;
    while (n_coef + n_restart + n_step < goal) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          b.mode       = 2'($urandom);
          b.coef_index = COEF_AW'($urandom);
          b.coef_value = $urandom;
          b.drive_x    = $urandom;
          b.drive_y    = $urandom;
          b.drive_z    = $urandom;
          send_beat(b);
        end
      end else begin
        n = $urandom_range(0, 6);
        repeat (n) send_beat(coef_beat(COEF_AW'($urandom_range(0, NCOEF - 1)), rand_q()));
        send_beat(run_beat(MODE_RESTART, rand_q(), rand_q(), rand_q()));
        n = $urandom_range(3, 12);
        repeat (n) send_beat(run_beat(MODE_STEP, rand_q(), rand_q(), rand_q()));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.data  = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, ignored beats, speed saturation
    send_beat(run_beat(MODE_RESTART, '0, '0, '0));
    send_beat(run_beat(MODE_STEP, Q_MAX, Q_MAX, Q_MAX));
    send_beat(run_beat(MODE_STEP, Q_MIN, Q_MIN, Q_MIN));
    send_beat(coef_beat(5'd0, Q_MAX));
    send_beat(coef_beat(5'd29, Q_MIN));
    send_beat(coef_beat(5'd30, Q_ONE));
    send_beat(coef_beat(5'd31, Q_MAX));
    send_beat(run_beat(MODE_UNUSED, Q_MAX, Q_MIN, Q_ONE));
    send_beat(coef_beat(5'd11, Q_ONE));
    send_beat(coef_beat(5'd14, Q_ONE));
    send_beat(run_beat(MODE_STEP, Q_ONE, '0, Q_MIN));
    settle();

    // huge start values: zero-weight squares still saturate
    write_reg(REG_START_X, Q_MAX);
    write_reg(REG_START_Y, Q_MIN);
    write_reg(REG_START_Z, Q_ONE);
    write_reg(REG_TIME_STEP, 32'h7fff_ffff);
    write_reg(REG_GAIN_X, Q_MAX);
    write_reg(REG_GAIN_Y, Q_MIN);
    write_reg(REG_GAIN_Z, '0);
    send_beat(run_beat(MODE_RESTART, '0, '0, '0));
    send_beat(run_beat(MODE_STEP, Q_MAX, '0, Q_MIN));
    send_beat(coef_beat(5'd0, '0));
    send_beat(coef_beat(5'd29, '0));
    send_beat(run_beat(MODE_STEP, '0, '0, '0));

    for (p = 0; p < PHASES; p++) begin
      settle();
      load_setting(p);
      run_phase(p);
    end
    settle();

    $display("Covered %0d coefficient writes, %0d restarts, %0d steps and %0d ignored beats,",
             n_coef, n_restart, n_step, n_ignored);
    $display("over %0d register writes in %0d settings, with a long output hold and drains.",
             n_regs, PHASES + 2);
    if (errors == 0 && points_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/qode3_pkg.sv
design/qode3_chan_if.sv
design/quadratic_ode3_euler_step.sv
tb/sv/quadratic_ode3_euler_step_checker.sv
tb/sv/quadratic_ode3_euler_step_tb.sv
